// ===== src/aaf_pkg.sv =====
package aaf_pkg;

    localparam int CMD_W  = 5;
    localparam int DATA_W = 8;

    // command codes
    localparam logic [CMD_W-1:0] CMD_ADD = 5'd0;
    localparam logic [CMD_W-1:0] CMD_ADC = 5'd1;
    localparam logic [CMD_W-1:0] CMD_SUB = 5'd2;
    localparam logic [CMD_W-1:0] CMD_SBB = 5'd3;
    localparam logic [CMD_W-1:0] CMD_ANA = 5'd4;
    localparam logic [CMD_W-1:0] CMD_XRA = 5'd5;
    localparam logic [CMD_W-1:0] CMD_ORA = 5'd6;
    localparam logic [CMD_W-1:0] CMD_CMP = 5'd7;
    localparam logic [CMD_W-1:0] CMD_RLC = 5'd8;
    localparam logic [CMD_W-1:0] CMD_RRC = 5'd9;
    localparam logic [CMD_W-1:0] CMD_RAL = 5'd10;
    localparam logic [CMD_W-1:0] CMD_RAR = 5'd11;
    localparam logic [CMD_W-1:0] CMD_CMA = 5'd12;
    localparam logic [CMD_W-1:0] CMD_CMC = 5'd13;
    localparam logic [CMD_W-1:0] CMD_STC = 5'd14;
    localparam logic [CMD_W-1:0] CMD_DAA = 5'd15;
    localparam logic [CMD_W-1:0] CMD_INR = 5'd16;
    localparam logic [CMD_W-1:0] CMD_DCR = 5'd17;
    localparam logic [CMD_W-1:0] CMD_LDA = 5'd18;
    localparam logic [CMD_W-1:0] CMD_PSW = 5'd19;

    // psw bit positions
    localparam int PSW_S  = 7;
    localparam int PSW_Z  = 6;
    localparam int PSW_AC = 4;
    localparam int PSW_P  = 2;
    localparam int PSW_CY = 0;

    localparam logic [3:0] DAA_LIMIT = 4'd9;
    localparam logic [3:0] DAA_STEP  = 4'd6;

    typedef struct packed {
        logic sign;
        logic zero;
        logic aux;
        logic parity;
        logic carry;
    } aaf_flags_t;

    function automatic logic [DATA_W-1:0] pack_psw(aaf_flags_t f);
        logic [DATA_W-1:0] p;
        p         = 8'h02;
        p[PSW_S]  = f.sign;
        p[PSW_Z]  = f.zero;
        p[PSW_AC] = f.aux;
        p[PSW_P]  = f.parity;
        p[PSW_CY] = f.carry;
        return p;
    endfunction

    function automatic aaf_flags_t unpack_psw(logic [DATA_W-1:0] p);
        aaf_flags_t f;
        f.sign   = p[PSW_S];
        f.zero   = p[PSW_Z];
        f.aux    = p[PSW_AC];
        f.parity = p[PSW_P];
        f.carry  = p[PSW_CY];
        return f;
    endfunction

endpackage

// ===== src/aaf_core.sv =====
module aaf_core (
    input  logic [aaf_pkg::CMD_W-1:0]  cmd,
    input  logic [aaf_pkg::DATA_W-1:0] operand,
    input  logic [aaf_pkg::DATA_W-1:0] psw_in,
    input  logic [aaf_pkg::DATA_W-1:0] acc,
    input  aaf_pkg::aaf_flags_t        flags,
    output logic [aaf_pkg::DATA_W-1:0] acc_next,
    output logic [aaf_pkg::DATA_W-1:0] op_result,
    output aaf_pkg::aaf_flags_t        flags_next
);
    import aaf_pkg::*;

    logic [DATA_W-1:0] add_b;
    logic              add_cin;
    logic              add_inv;
    logic [DATA_W:0]   add_sum;
    logic [4:0]        add_low;
    logic [3:0]        lo;
    logic [3:0]        hi;
    logic              daa_lo;
    logic              daa_hi;
    logic [DATA_W-1:0] daa_corr;
    logic [DATA_W-1:0] daa_sum;
    logic [4:0]        daa_low;
    logic [DATA_W-1:0] inc_val;
    logic [DATA_W-1:0] dec_val;

    // shared adder for add/adc/sub/sbb/cmp; subtraction adds the complement
    always_comb begin
        add_inv = (cmd == CMD_SUB) || (cmd == CMD_SBB) || (cmd == CMD_CMP);
        add_b   = add_inv ? ~operand : operand;
        unique case (cmd)
            CMD_ADC:          add_cin = flags.carry;
            CMD_SUB, CMD_CMP: add_cin = 1'b1;
            CMD_SBB:          add_cin = ~flags.carry;
            default:          add_cin = 1'b0;
        endcase
        add_sum = {1'b0, acc} + {1'b0, add_b} + {{DATA_W{1'b0}}, add_cin};
        add_low = {1'b0, acc[3:0]} + {1'b0, add_b[3:0]} + {4'd0, add_cin};
    end

    always_comb begin
        lo       = acc[3:0];
        hi       = acc[7:4];
        daa_lo   = flags.aux || (lo > DAA_LIMIT);
        daa_hi   = flags.carry || (hi > DAA_LIMIT) || ((hi >= DAA_LIMIT) && (lo > DAA_LIMIT));
        daa_corr = {(daa_hi ? DAA_STEP : 4'd0), (daa_lo ? DAA_STEP : 4'd0)};
        daa_sum  = acc + daa_corr;
        daa_low  = {1'b0, lo} + {1'b0, daa_corr[3:0]};
        inc_val  = operand + 8'd1;
        dec_val  = operand - 8'd1;
    end

    function automatic aaf_flags_t zsp(aaf_flags_t f, logic [DATA_W-1:0] v);
        aaf_flags_t r;
        r        = f;
        r.sign   = v[DATA_W-1];
        r.zero   = (v == '0);
        r.parity = ~^v;
        return r;
    endfunction

    always_comb begin
        acc_next   = acc;
        flags_next = flags;
        op_result  = '0;
        unique case (cmd)
            CMD_ADD, CMD_ADC, CMD_SUB, CMD_SBB, CMD_CMP: begin
                if (cmd != CMD_CMP) begin
                    acc_next = add_sum[DATA_W-1:0];
                end
                flags_next       = zsp(flags, add_sum[DATA_W-1:0]);
                flags_next.carry = add_sum[DATA_W] ^ add_inv;
                flags_next.aux   = add_low[4];
            end
            CMD_ANA, CMD_XRA, CMD_ORA: begin
                if (cmd == CMD_ANA) begin
                    acc_next = acc & operand;
                end else if (cmd == CMD_XRA) begin
                    acc_next = acc ^ operand;
                end else begin
                    acc_next = acc | operand;
                end
                flags_next       = zsp(flags, acc_next);
                flags_next.carry = 1'b0;
                flags_next.aux   = 1'b0;
            end
            CMD_RLC: begin
                acc_next         = {acc[6:0], acc[7]};
                flags_next.carry = acc[7];
            end
            CMD_RRC: begin
                acc_next         = {acc[0], acc[7:1]};
                flags_next.carry = acc[0];
            end
            CMD_RAL: begin
                acc_next         = {acc[6:0], flags.carry};
                flags_next.carry = acc[7];
            end
            CMD_RAR: begin
                acc_next         = {flags.carry, acc[7:1]};
                flags_next.carry = acc[0];
            end
            CMD_CMA: acc_next = ~acc;
            CMD_CMC: flags_next.carry = ~flags.carry;
            CMD_STC: flags_next.carry = 1'b1;
            CMD_DAA: begin
                acc_next         = daa_sum;
                flags_next       = zsp(flags, daa_sum);
                flags_next.aux   = daa_low[4];
                flags_next.carry = flags.carry | daa_hi;
            end
            CMD_INR: begin
                op_result      = inc_val;
                flags_next     = zsp(flags, inc_val);
                flags_next.aux = (operand[3:0] == 4'hf);
            end
            CMD_DCR: begin
                op_result      = dec_val;
                flags_next     = zsp(flags, dec_val);
                flags_next.aux = (operand[3:0] != 4'h0);
            end
            CMD_LDA: acc_next = operand;
            CMD_PSW: flags_next = unpack_psw(psw_in);
            default: ;  // unused codes change nothing
        endcase
        if ((cmd != CMD_INR) && (cmd != CMD_DCR)) begin
            op_result = acc_next;
        end
    end

endmodule

// ===== src/accumulator_alu_with_flags.sv =====
// channel | ports                                  | role
// s_      | s_valid s_ready s_command s_operand s_psw_in | one command beat in
// m_      | m_valid m_ready m_accumulator m_op_result m_psw | one result beat out
//
// One beat per clock sustained while m_ready stays high. A beat is held in
// the input register, then the ALU and the accumulator/flag state update as
// it moves to the result register. aresetn (synchronous, active low) clears
// the accumulator, flags and valids. A stall on m_ready holds the result;
// s_ready drops only once both registers are full.
module accumulator_alu_with_flags (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [aaf_pkg::CMD_W-1:0]  s_command,
    input  logic [aaf_pkg::DATA_W-1:0] s_operand,
    input  logic [aaf_pkg::DATA_W-1:0] s_psw_in,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [aaf_pkg::DATA_W-1:0] m_accumulator,
    output logic [aaf_pkg::DATA_W-1:0] m_op_result,
    output logic [aaf_pkg::DATA_W-1:0] m_psw
);
    import aaf_pkg::*;

    logic              in_valid_reg;
    logic [CMD_W-1:0]  in_cmd_reg;
    logic [DATA_W-1:0] in_operand_reg;
    logic [DATA_W-1:0] in_psw_reg;
    logic              out_valid_reg;
    logic [DATA_W-1:0] out_acc_reg;
    logic [DATA_W-1:0] out_opres_reg;
    logic [DATA_W-1:0] out_psw_reg;
    logic [DATA_W-1:0] acc_reg;
    aaf_flags_t        flags_reg;

    logic [DATA_W-1:0] acc_next;
    logic [DATA_W-1:0] opres_next;
    aaf_flags_t        flags_next;
    logic              advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    aaf_core u_core (
        .cmd        (in_cmd_reg),
        .operand    (in_operand_reg),
        .psw_in     (in_psw_reg),
        .acc        (acc_reg),
        .flags      (flags_reg),
        .acc_next   (acc_next),
        .op_result  (opres_next),
        .flags_next (flags_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            acc_reg       <= '0;
            flags_reg     <= '0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                acc_reg       <= acc_next;
                flags_reg     <= flags_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_cmd_reg     <= s_command;
            in_operand_reg <= s_operand;
            in_psw_reg     <= s_psw_in;
        end
        if (advance) begin
            out_acc_reg   <= acc_next;
            out_opres_reg <= opres_next;
            out_psw_reg   <= pack_psw(flags_next);
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_accumulator = out_acc_reg;
    assign m_op_result   = out_opres_reg;
    assign m_psw         = out_psw_reg;

endmodule

// ===== src/aaf_checker.sv =====
module aaf_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_valid,
    input logic                       s_ready,
    input logic [aaf_pkg::CMD_W-1:0]  s_command,
    input logic [aaf_pkg::DATA_W-1:0] s_operand,
    input logic [aaf_pkg::DATA_W-1:0] s_psw_in,
    input logic                       m_valid,
    input logic                       m_ready,
    input logic [aaf_pkg::DATA_W-1:0] m_accumulator,
    input logic [aaf_pkg::DATA_W-1:0] m_op_result,
    input logic [aaf_pkg::DATA_W-1:0] m_psw
);
    import aaf_pkg::*;

    // fixed psw bits: bit1 set, bits 5 and 3 clear
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_psw[1] == 1'b1) && (m_psw[5] == 1'b0) && (m_psw[3] == 1'b0))
        else $error("psw fixed bits wrong");

    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // input side only backs up behind a stalled result
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled without output stall");

    // an accepted beat is followed by a valid result on m_valid
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |-> ##2 m_valid)
        else $error("accepted beat produced no result");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_accumulator)
            && $stable(m_op_result) && $stable(m_psw))
        else $error("stalled result changed");

endmodule

bind accumulator_alu_with_flags aaf_checker u_aaf_checker (.*);
